[rtl/core/fls_pkg.sv]
// Shared types, codes and defaults for the weighted FIFO/LIFO server.
package fls_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int STACK_DEPTH_DEF = 64;
  localparam logic [3:0] QUOTA_RESET = 4'd3;

  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_PUSH    = 2'd1;
  localparam logic [1:0] REQ_SERVE   = 2'd2;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_SERVED  = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_QPUSH = 3'd1;
  localparam logic [2:0] ACT_SPUSH = 3'd2;
  localparam logic [2:0] ACT_QPOP  = 3'd3;
  localparam logic [2:0] ACT_SPOP  = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [11:0] minutes;
  } entry_t;

  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic s_empty;
    logic s_full;
  } fill_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] act;
    logic [3:0] round_nxt;
  } dec_t;

endpackage

[rtl/core/fls_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/fls_policy.sv]
// Serving policy: picks the store action, status and next round count.
module fls_policy
  import fls_pkg::*;
(
  input  logic [1:0] req,
  input  fill_t      fill,
  input  logic [3:0] round_served,
  input  logic [3:0] quota,
  output dec_t       dec
);

  always_comb begin
    dec.status    = ST_NOTHING;
    dec.act       = ACT_NONE;
    dec.round_nxt = round_served;
    case (req)
      REQ_ENQUEUE: begin
        if (fill.q_full) begin
          dec.status = ST_FULL;
        end else begin
          dec.status = ST_STORED;
          dec.act    = ACT_QPUSH;
        end
      end
      REQ_PUSH: begin
        if (fill.s_full) begin
          dec.status = ST_FULL;
        end else begin
          dec.status = ST_STORED;
          dec.act    = ACT_SPUSH;
        end
      end
      REQ_SERVE: begin
        if (!fill.q_empty && (round_served < quota)) begin
          dec.status    = ST_SERVED;
          dec.act       = ACT_QPOP;
          dec.round_nxt = round_served + 4'd1;
        end else if (!fill.s_empty) begin
          dec.status    = ST_SERVED;
          dec.act       = ACT_SPOP;
          dec.round_nxt = 4'd0;
        end else if (!fill.q_empty) begin
          // restart the round on the queue
          dec.status    = ST_SERVED;
          dec.act       = ACT_QPOP;
          dec.round_nxt = 4'd1;
        end
      end
      default: begin
        dec.status = ST_NOTHING;
      end
    endcase
  end

endmodule

[rtl/core/fifo_lifo_weighted_server.sv]
// Top level of the weighted FIFO/LIFO server.
// Each request is accepted and decided against the counters while the
// entry memory is read, and its result is loaded into the output register
// once that register is free. A new request is taken while a finished
// result still waits downstream, but not while one is still pending, since
// the entry memories have registered read data. Both memories need no
// clearing pass.
module fifo_lifo_weighted_server
  import fls_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_customer_id,
  input  logic [11:0] in_service_minutes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_served_id,
  output logic        out_served_missed,
  output logic [11:0] out_served_minutes,
  output logic [31:0] out_order_number,
  output logic [31:0] out_total_minutes
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  logic [3:0]     quota_r;
  logic [QAW-1:0] q_rd_ptr_r, q_wr_ptr_r;
  logic [QCW-1:0] q_cnt_r;
  logic [SCW-1:0] s_cnt_r, s_cnt_m1;
  logic [3:0]     round_r;
  logic [31:0]    served_cnt_r, minutes_r;
  logic [32:0]    minutes_sum;
  logic [31:0]    minutes_nxt;

  logic           pend_r, pend_pop_r, pend_missed_r;
  logic [1:0]     pend_status_r;
  logic           out_valid_r;

  fill_t  fill;
  dec_t   dec;
  entry_t in_entry, q_rdata, s_rdata, sel;
  logic   acc, complete;
  logic   q_we, q_re, s_we, s_re;

  assign acc      = in_valid && !pend_r;
  assign in_stall = pend_r;
  assign complete = pend_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  assign fill.q_empty = (q_cnt_r == '0);
  assign fill.q_full  = (q_cnt_r == QCW'(QUEUE_DEPTH));
  assign fill.s_empty = (s_cnt_r == '0);
  assign fill.s_full  = (s_cnt_r == SCW'(STACK_DEPTH));

  fls_policy u_policy (
    .req          (in_req_type),
    .fill         (fill),
    .round_served (round_r),
    .quota        (quota_r),
    .dec          (dec)
  );

  assign in_entry.id      = in_customer_id;
  assign in_entry.minutes = in_service_minutes;
  assign s_cnt_m1 = s_cnt_r - SCW'(1);

  assign q_we = acc && (dec.act == ACT_QPUSH);
  assign q_re = acc && (dec.act == ACT_QPOP);
  assign s_we = acc && (dec.act == ACT_SPUSH);
  assign s_re = acc && (dec.act == ACT_SPOP);

  fls_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_wr_ptr_r),
    .wdata (in_entry),
    .re    (q_re),
    .raddr (q_rd_ptr_r),
    .rdata (q_rdata)
  );

  fls_ram #(.WIDTH($bits(entry_t)), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_cnt_r[SAW-1:0]),
    .wdata (in_entry),
    .re    (s_re),
    .raddr (s_cnt_m1[SAW-1:0]),
    .rdata (s_rdata)
  );

  always_comb begin
    sel = pend_missed_r ? s_rdata : q_rdata;
    if (!pend_pop_r) begin
      sel = '0;
    end
  end

  assign minutes_sum = {1'b0, minutes_r} + {21'd0, sel.minutes};
  assign minutes_nxt = minutes_sum[32] ? 32'hFFFF_FFFF : minutes_sum[31:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r      <= QUOTA_RESET;
      q_rd_ptr_r   <= '0;
      q_wr_ptr_r   <= '0;
      q_cnt_r      <= '0;
      s_cnt_r      <= '0;
      round_r      <= '0;
      served_cnt_r <= '0;
      minutes_r    <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        quota_r <= cfg_data;
      end
      if (acc) begin
        pend_r  <= 1'b1;
        round_r <= dec.round_nxt;
        case (dec.act)
          ACT_QPUSH: begin
            q_wr_ptr_r <= (q_wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_wr_ptr_r + QAW'(1);
            q_cnt_r    <= q_cnt_r + QCW'(1);
          end
          ACT_SPUSH: s_cnt_r <= s_cnt_r + SCW'(1);
          ACT_QPOP: begin
            q_rd_ptr_r <= (q_rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_rd_ptr_r + QAW'(1);
            q_cnt_r    <= q_cnt_r - QCW'(1);
          end
          ACT_SPOP: s_cnt_r <= s_cnt_m1;
          default: begin
          end
        endcase
        if ((dec.act == ACT_QPOP || dec.act == ACT_SPOP) && (served_cnt_r != 32'hFFFF_FFFF)) begin
          served_cnt_r <= served_cnt_r + 32'd1;
        end
      end
      if (complete) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
        minutes_r   <= minutes_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status_r <= dec.status;
      pend_pop_r    <= (dec.act == ACT_QPOP) || (dec.act == ACT_SPOP);
      pend_missed_r <= (dec.act == ACT_SPOP);
    end
    if (complete) begin
      out_status         <= pend_status_r;
      out_served_id      <= sel.id;
      out_served_minutes <= sel.minutes;
      out_served_missed  <= pend_missed_r && pend_pop_r;
      out_order_number   <= served_cnt_r;
      out_total_minutes  <= minutes_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_cnt_r <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_result_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result without a pending request");

  a_served_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> served_cnt_r >= $past(served_cnt_r))
    else $error("served count went backward");
`endif

endmodule
